>>> hw/rtl/scs_pkg.sv
// Shared types and constants for the stair climb sequencer.
// No dependencies; used by scs_cfg_regs, scs_core and the top level.
package scs_pkg;

  localparam int PITCH_W  = 13;
  localparam int LIMIT_W  = 16;
  localparam int TARGET_W = 24;
  localparam int STEP_W   = 16;
  localparam int CFF_W    = 14;
  localparam int SFF_W    = 15;
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 24;
  localparam int SUM_W    = TARGET_W + 2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO_FORCE = 3'd0,
    MODE_NO_FOLLOW  = 3'd1,
    MODE_FOLLOW_YAW = 3'd2,
    MODE_ROTATE     = 3'd3,
    MODE_REV_ROTATE = 3'd4
  } mode_t;

  localparam logic [INDEX_W-1:0] REG_RISE_PITCH    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LEVEL_PITCH   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_FINISH_PITCH  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RISE_COUNT    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LEVEL_COUNT   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_FINISH_COUNT  = 3'd5;
  localparam logic [INDEX_W-1:0] REG_STAGE2_TMO    = 3'd6;
  localparam logic [INDEX_W-1:0] REG_FULL_TRAVEL   = 3'd7;

  localparam logic signed [CFF_W-1:0] CFF_UP    = 14'sd8000;
  localparam logic signed [CFF_W-1:0] CFF_DOWN  = -14'sd8000;
  localparam logic signed [SFF_W-1:0] SFF_DOWN  = -15'sd10000;

  typedef struct packed {
    logic signed [PITCH_W-1:0] rise_pitch;
    logic signed [PITCH_W-1:0] level_pitch;
    logic signed [PITCH_W-1:0] finish_pitch;
    logic [LIMIT_W-1:0]        rise_count;
    logic [LIMIT_W-1:0]        level_count;
    logic [LIMIT_W-1:0]        finish_count;
    logic [LIMIT_W-1:0]        stage2_timeout;
    logic [TARGET_W-1:0]       full_travel;
  } cfg_t;

endpackage

>>> hw/rtl/stair_climb_sequencer.sv
// Stair climb sequencer top level: input register, handshake, config port.
// Depends on scs_pkg, scs_cfg_regs and scs_core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  s_axis   | s_tvalid / s_tready  | s_tdata: mode, calibrated, pitch, step
//  m_axis   | m_tvalid / m_tready  | m_tdata: phase, target, current/speed ff
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while m_tready is high; the input register feeds
// the state/result register, updated in a single pass. Reset loads register
// defaults and sets the phase to stage one; no clearing pass. With m_tready
// low the result holds, the input register fills and s_tready drops.
module stair_climb_sequencer #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] drive_mode, [3] calibrated, [16:4] pitch, [32:17] putter_step
  input  logic [39:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] climb_phase, [25:2] putter_target, [39:26] current_ff,
  // [54:40] speed_ff
  output logic [55:0]                       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scs_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [scs_pkg::DATA_W-1:0]        cfg_data
);
  import scs_pkg::*;

  cfg_t                       cfg;
  logic                       in_valid;
  logic [MODE_W-1:0]          in_mode;
  logic                       in_cal;
  logic signed [PITCH_W-1:0]  in_pitch;
  logic signed [STEP_W-1:0]   in_step;
  logic                       adv;
  phase_t                     phase;
  logic [TARGET_W-1:0]        target;
  logic signed [CFF_W-1:0]    cur_ff;
  logic signed [SFF_W-1:0]    spd_ff;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode  <= s_tdata[2:0];
      in_cal   <= s_tdata[3];
      in_pitch <= s_tdata[16:4];
      in_step  <= s_tdata[32:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  scs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  scs_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .mode        (in_mode),
    .calibrated  (in_cal),
    .pitch       (in_pitch),
    .putter_step (in_step),
    .cfg         (cfg),
    .phase       (phase),
    .target      (target),
    .cur_ff      (cur_ff),
    .spd_ff      (spd_ff)
  );

  assign m_tdata = {1'b0, spd_ff, cur_ff, target, phase};

endmodule

>>> hw/rtl/scs_cfg_regs.sv
// Configuration register file of the stair climb sequencer.
// Depends on scs_pkg.
module scs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [scs_pkg::INDEX_W-1:0]  wr_index,
  input  logic [scs_pkg::DATA_W-1:0]   wr_data,
  output scs_pkg::cfg_t                cfg
);
  import scs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_pitch     <= 13'sd336;
      cfg.level_pitch    <= 13'sd64;
      cfg.finish_pitch   <= 13'sd16;
      cfg.rise_count     <= 16'd250;
      cfg.level_count    <= 16'd250;
      cfg.finish_count   <= 16'd250;
      cfg.stage2_timeout <= 16'd2500;
      cfg.full_travel    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_RISE_PITCH:   cfg.rise_pitch     <= wr_data[PITCH_W-1:0];
        REG_LEVEL_PITCH:  cfg.level_pitch    <= wr_data[PITCH_W-1:0];
        REG_FINISH_PITCH: cfg.finish_pitch   <= wr_data[PITCH_W-1:0];
        REG_RISE_COUNT:   cfg.rise_count     <= wr_data[LIMIT_W-1:0];
        REG_LEVEL_COUNT:  cfg.level_count    <= wr_data[LIMIT_W-1:0];
        REG_FINISH_COUNT: cfg.finish_count   <= wr_data[LIMIT_W-1:0];
        REG_STAGE2_TMO:   cfg.stage2_timeout <= wr_data[LIMIT_W-1:0];
        REG_FULL_TRAVEL:  cfg.full_travel    <= wr_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/scs_core.sv
// Climb phase machine, counters, putter target and feedforward state.
// The state registers double as the result register. Depends on scs_pkg.
module scs_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic [scs_pkg::MODE_W-1:0]         mode,
  input  logic                               calibrated,
  input  logic signed [scs_pkg::PITCH_W-1:0] pitch,
  input  logic signed [scs_pkg::STEP_W-1:0]  putter_step,
  input  scs_pkg::cfg_t                      cfg,
  output scs_pkg::phase_t                    phase,
  output logic [scs_pkg::TARGET_W-1:0]       target,
  output logic signed [scs_pkg::CFF_W-1:0]   cur_ff,
  output logic signed [scs_pkg::SFF_W-1:0]   spd_ff
);
  import scs_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [COUNT_BITS-1:0]     qcount, qcount_next;
  logic [COUNT_BITS-1:0]     tcount, tcount_next;
  phase_t                    phase_next;
  logic [TARGET_W-1:0]       target_next;
  logic signed [CFF_W-1:0]   cur_ff_next;
  logic signed [SFF_W-1:0]   spd_ff_next;
  logic signed [SUM_W-1:0]   tgt;
  logic signed [SUM_W-1:0]   full_ext;
  logic                      hit;
  logic [CMP_W-1:0]          limit;
  logic                      done;

  always_comb begin
    phase_next  = phase;
    qcount_next = qcount;
    tcount_next = tcount;
    cur_ff_next = cur_ff;
    spd_ff_next = spd_ff;
    tgt         = signed'({2'b00, target});
    full_ext    = signed'({2'b00, cfg.full_travel});
    hit         = 1'b0;
    limit       = '0;
    done        = 1'b0;

    if (mode == MODE_ZERO_FORCE || !calibrated) begin
      phase_next  = PH_WAIT;
      qcount_next = '0;
      tcount_next = '0;
      cur_ff_next = '0;
      spd_ff_next = '0;
    end

    if (mode inside {MODE_NO_FOLLOW, MODE_ROTATE, MODE_REV_ROTATE}) begin
      tgt = '0;
    end else if (mode == MODE_FOLLOW_YAW) begin
      tgt = tgt + SUM_W'(putter_step);
    end

    if (mode != MODE_FOLLOW_YAW) begin
      phase_next  = PH_WAIT;
      qcount_next = '0;
      tcount_next = '0;
      cur_ff_next = '0;
      spd_ff_next = '0;
    end else begin
      case (phase_next)
        PH_WAIT: begin
          hit         = pitch > cfg.rise_pitch;
          qcount_next = hit ? qcount_next + 1'b1 : '0;
          limit       = CMP_W'(cfg.rise_count);
          if (CMP_W'(qcount_next) >= limit) begin
            phase_next  = PH_ONE;
            qcount_next = '0;
            tgt         = full_ext;
            cur_ff_next = CFF_UP;
          end
        end
        PH_ONE: begin
          hit         = pitch < cfg.level_pitch;
          qcount_next = hit ? qcount_next + 1'b1 : '0;
          limit       = CMP_W'(cfg.level_count);
          if (CMP_W'(qcount_next) >= limit) begin
            phase_next  = PH_TWO;
            qcount_next = '0;
            tgt         = '0;
            cur_ff_next = CFF_DOWN;
            spd_ff_next = SFF_DOWN;
          end
        end
        default: begin
          hit         = pitch < cfg.finish_pitch;
          qcount_next = hit ? qcount_next + 1'b1 : '0;
          tcount_next = tcount_next + 1'b1;
          limit       = CMP_W'(cfg.finish_count);
          done        = (CMP_W'(qcount_next) >= limit) ||
                        (CMP_W'(tcount_next) >= CMP_W'(cfg.stage2_timeout));
          if (done) begin
            phase_next  = PH_WAIT;
            qcount_next = '0;
            tcount_next = '0;
            cur_ff_next = '0;
            spd_ff_next = '0;
            tgt         = '0;
          end
        end
      endcase
    end

    if (tgt < 0) begin
      target_next = '0;
    end else if (tgt > full_ext) begin
      target_next = cfg.full_travel;
    end else begin
      target_next = tgt[TARGET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_ONE;
      qcount <= '0;
      tcount <= '0;
      target <= '0;
      cur_ff <= '0;
      spd_ff <= '0;
    end else if (en) begin
      phase  <= phase_next;
      qcount <= qcount_next;
      tcount <= tcount_next;
      target <= target_next;
      cur_ff <= cur_ff_next;
      spd_ff <= spd_ff_next;
    end
  end

endmodule

>>> tb/sv/tb_stair_climb_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for stair_climb_sequencer: queued ticks, a per-tick model of
// the climb sequence, and a scoreboard on the result stream. Needs scs_pkg and the RTL.
module tb_stair_climb_sequencer;
  import scs_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PITCH_MAX = 2880;

  typedef struct packed {
    logic signed [STEP_W-1:0]  step;
    logic signed [PITCH_W-1:0] pitch;
    logic                      cal;
    logic [MODE_W-1:0]         mode;
  } tick_t;

  typedef struct packed {
    logic signed [SFF_W-1:0] sff;
    logic signed [CFF_W-1:0] cff;
    logic [TARGET_W-1:0]     tgt;
    logic [1:0]              ph;
  } climb_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;

  stair_climb_sequencer #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  tick_t       tick_queue[$];
  climb_word_t predicted_words[$];
  tick_t       cur_tick;
  bit          stall_en = 1'b1;
  int          queued = 0;
  int          ticks_in = 0;
  int          words_out = 0;
  int          mismatches = 0;
  int          settings = 0;
  int          climbs_started = 0;
  int          climbs_ended = 0;
  int          quiet = 0;

  // sequencer model state
  cfg_t                     cfg;
  phase_t                   ph;
  logic [COUNT_BITS-1:0]    qual_cnt;
  logic [COUNT_BITS-1:0]    tmo_cnt;
  longint                   tgt_pos;
  logic signed [CFF_W-1:0]  cur_ff;
  logic signed [SFF_W-1:0]  spd_ff;

  task automatic clear_sequence();
    ph = PH_WAIT;
    qual_cnt = '0;
    tmo_cnt = '0;
    cur_ff = '0;
    spd_ff = '0;
  endtask

  task automatic climb_predict(input tick_t t, output climb_word_t r);
    longint full;
    full = longint'(cfg.full_travel);
    if (t.mode == MODE_ZERO_FORCE || !t.cal) clear_sequence();
    if (t.mode == MODE_NO_FOLLOW || t.mode == MODE_ROTATE || t.mode == MODE_REV_ROTATE)
      tgt_pos = 0;
    else if (t.mode == MODE_FOLLOW_YAW)
      tgt_pos = tgt_pos + longint'($signed(t.step));
    if (t.mode != MODE_FOLLOW_YAW) begin
      clear_sequence();
    end else begin
      case (ph)
        PH_WAIT: begin
          qual_cnt = ($signed(t.pitch) > $signed(cfg.rise_pitch)) ? qual_cnt + 1'b1 : '0;
          if (qual_cnt >= cfg.rise_count) begin
            ph = PH_ONE;
            qual_cnt = '0;
            tgt_pos = full;
            cur_ff = CFF_UP;
            climbs_started++;
          end
        end
        PH_ONE: begin
          qual_cnt = ($signed(t.pitch) < $signed(cfg.level_pitch)) ? qual_cnt + 1'b1 : '0;
          if (qual_cnt >= cfg.level_count) begin
            ph = PH_TWO;
            qual_cnt = '0;
            tgt_pos = 0;
            cur_ff = CFF_DOWN;
            spd_ff = SFF_DOWN;
          end
        end
        default: begin
          qual_cnt = ($signed(t.pitch) < $signed(cfg.finish_pitch)) ? qual_cnt + 1'b1 : '0;
          tmo_cnt = tmo_cnt + 1'b1;
          if (qual_cnt >= cfg.finish_count || tmo_cnt >= cfg.stage2_timeout) begin
            clear_sequence();
            tgt_pos = 0;
            climbs_ended++;
          end
        end
      endcase
    end
    if (tgt_pos < 0) tgt_pos = 0;
    else if (tgt_pos > full) tgt_pos = full;
    r.ph = ph;
    r.tgt = tgt_pos[TARGET_W-1:0];
    r.cff = cur_ff;
    r.sff = spd_ff;
  endtask

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d (word %0d)", field, got, want, words_out);
    mismatches++;
  endtask

  // driver: predict on accept, then present the next queued word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        climb_word_t w;
        climb_predict(cur_tick, w);
        predicted_words.push_back(w);
        ticks_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && !(stall_en && $urandom_range(99) < 12)) begin
          cur_tick = tick_queue.pop_front();
          s_tdata <= {7'b0, cur_tick};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        climb_word_t got, want;
        got = climb_word_t'(m_tdata[54:0]);
        if (predicted_words.size() == 0) begin
          flag_mismatch("unexpected word, climb_phase", int'(got.ph), -1);
        end else begin
          want = predicted_words.pop_front();
          if (got.ph !== want.ph) flag_mismatch("climb_phase", int'(got.ph), int'(want.ph));
          if (got.tgt !== want.tgt)
            flag_mismatch("putter_target", int'(got.tgt), int'(want.tgt));
          if (got.cff !== want.cff)
            flag_mismatch("current_ff", int'($signed(got.cff)), int'($signed(want.cff)));
          if (got.sff !== want.sff)
            flag_mismatch("speed_ff", int'($signed(got.sff)), int'($signed(want.sff)));
        end
        words_out++;
      end
      m_tready <= !(stall_en && $urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // call right after a rising edge; leaves cfg_valid high for a following write
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RISE_PITCH:   cfg.rise_pitch = val[PITCH_W-1:0];
      REG_LEVEL_PITCH:  cfg.level_pitch = val[PITCH_W-1:0];
      REG_FINISH_PITCH: cfg.finish_pitch = val[PITCH_W-1:0];
      REG_RISE_COUNT:   cfg.rise_count = val[LIMIT_W-1:0];
      REG_LEVEL_COUNT:  cfg.level_count = val[LIMIT_W-1:0];
      REG_FINISH_COUNT: cfg.finish_count = val[LIMIT_W-1:0];
      REG_STAGE2_TMO:   cfg.stage2_timeout = val[LIMIT_W-1:0];
      default:          cfg.full_travel = val[TARGET_W-1:0];
    endcase
  endtask

  task automatic write_plan(input cfg_t p);
    write_reg(REG_RISE_PITCH, DATA_W'(p.rise_pitch));
    write_reg(REG_LEVEL_PITCH, DATA_W'(p.level_pitch));
    write_reg(REG_FINISH_PITCH, DATA_W'(p.finish_pitch));
    write_reg(REG_RISE_COUNT, DATA_W'(p.rise_count));
    write_reg(REG_LEVEL_COUNT, DATA_W'(p.level_count));
    write_reg(REG_FINISH_COUNT, DATA_W'(p.finish_count));
    write_reg(REG_STAGE2_TMO, DATA_W'(p.stage2_timeout));
    write_reg(REG_FULL_TRAVEL, DATA_W'(p.full_travel));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || s_tvalid || predicted_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_tick(input logic [MODE_W-1:0] m, input bit c, input int p, input int s);
    tick_t t;
    t.mode = m;
    t.cal = c;
    t.pitch = PITCH_W'(p);
    t.step = STEP_W'(s);
    tick_queue.push_back(t);
    queued++;
  endtask

  function automatic int clamp_pitch(int v);
    return (v > PITCH_MAX) ? PITCH_MAX : (v < -PITCH_MAX) ? -PITCH_MAX : v;
  endfunction

  function automatic int pitch_in(int lo, int hi);
    int a, b;
    a = clamp_pitch(lo);
    b = clamp_pitch(hi);
    return a + int'($urandom_range(b - a, 0));
  endfunction

  function automatic int any_pitch();
    return pitch_in(-PITCH_MAX, PITCH_MAX);
  endfunction

  function automatic int op_step();
    if ($urandom_range(99) < 85) return int'($urandom_range(400, 0)) - 200;
    return int'($urandom);
  endfunction

  function automatic int seg_len(logic [LIMIT_W-1:0] n);
    return (n > 12) ? 12 : int'(n);
  endfunction

  task automatic push_noise();
    push_tick(MODE_W'($urandom), 1'($urandom), any_pitch(), int'($urandom));
  endtask

  // follow-yaw tick with the odd glitch in mode, calibration or pitch
  task automatic push_follow(input int p);
    int r;
    r = $urandom_range(99);
    if (r < 3) push_noise();
    else if (r < 7) push_tick(MODE_FOLLOW_YAW, 1'b1, any_pitch(), op_step());
    else push_tick(MODE_FOLLOW_YAW, 1'b1, p, op_step());
  endtask

  task automatic queue_climb(input cfg_t c);
    int rp, lp, fp;
    rp = $signed(c.rise_pitch);
    lp = $signed(c.level_pitch);
    fp = $signed(c.finish_pitch);
    repeat ($urandom_range(3, 0)) push_follow(pitch_in(rp - 300, rp));
    repeat (seg_len(c.rise_count) + $urandom_range(1, 0)) push_follow(pitch_in(rp + 1, rp + 300));
    repeat (seg_len(c.level_count) + $urandom_range(1, 0)) push_follow(pitch_in(lp - 300, lp - 1));
    if ($urandom_range(1, 0))
      repeat (seg_len(c.finish_count) + 1) push_follow(pitch_in(fp - 300, fp - 1));
    else
      repeat (seg_len(c.stage2_timeout) + 1) push_follow(pitch_in(fp, fp + 300));
  endtask

  function automatic cfg_t random_plan(int idx);
    cfg_t p;
    int rp, lp, fp;
    rp = $urandom_range(600, 0);
    lp = rp - int'($urandom_range(300, 0));
    fp = lp - int'($urandom_range(300, 0));
    if (idx == 6) begin
      rp = any_pitch();
      lp = any_pitch();
      fp = any_pitch();
    end
    p.rise_pitch = PITCH_W'(rp);
    p.level_pitch = PITCH_W'(lp);
    p.finish_pitch = PITCH_W'(fp);
    p.rise_count = LIMIT_W'($urandom_range(6, 1));
    p.level_count = LIMIT_W'($urandom_range(6, 1));
    p.finish_count = LIMIT_W'($urandom_range(6, 1));
    p.stage2_timeout = LIMIT_W'($urandom_range(30, 1));
    p.full_travel = (idx % 2) ? TARGET_W'($urandom) : TARGET_W'($urandom_range(5000, 0));
    if (idx == 1) begin
      p.rise_pitch = PITCH_W'(-PITCH_MAX);
      p.level_pitch = PITCH_W'(PITCH_MAX);
      p.finish_pitch = PITCH_W'(PITCH_MAX);
      p.rise_count = LIMIT_W'(1);
      p.level_count = LIMIT_W'(1);
      p.finish_count = LIMIT_W'(1);
      p.stage2_timeout = LIMIT_W'(1);
      p.full_travel = '1;
    end else if (idx == 2) begin
      p.rise_pitch = PITCH_W'(PITCH_MAX);
      p.level_pitch = PITCH_W'(-PITCH_MAX);
      p.finish_pitch = PITCH_W'(-PITCH_MAX);
      p.rise_count = '1;
      p.level_count = '1;
      p.finish_count = '1;
      p.stage2_timeout = '1;
      p.full_travel = '0;
    end else if (idx == 5) begin
      p.finish_count = '1;
      p.stage2_timeout = LIMIT_W'($urandom_range(8, 1));
    end
    return p;
  endfunction

  initial begin
    cfg_t plan;
    int   goal;
    cfg.rise_pitch = 13'sd336;
    cfg.level_pitch = 13'sd64;
    cfg.finish_pitch = 13'sd16;
    cfg.rise_count = 16'd250;
    cfg.level_count = 16'd250;
    cfg.finish_count = 16'd250;
    cfg.stage2_timeout = 16'd2500;
    cfg.full_travel = '0;
    clear_sequence();
    ph = PH_ONE;
    tgt_pos = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: machine starts in stage one, travel limit zero
    push_tick(MODE_FOLLOW_YAW, 1'b1, 0, 100);
    push_tick(MODE_FOLLOW_YAW, 1'b1, -PITCH_MAX, 32767);
    push_tick(MODE_ZERO_FORCE, 1'b1, 0, 0);
    push_tick(MODE_FOLLOW_YAW, 1'b1, PITCH_MAX, 5);
    drain();

    plan.rise_pitch = 13'sd300;
    plan.level_pitch = 13'sd60;
    plan.finish_pitch = 13'sd10;
    plan.rise_count = 16'd2;
    plan.level_count = 16'd2;
    plan.finish_count = 16'd2;
    plan.stage2_timeout = 16'd3;
    plan.full_travel = 24'd1000;
    write_plan(plan);
    push_tick(MODE_NO_FOLLOW, 1'b1, 0, 5);
    push_tick(MODE_ROTATE, 1'b1, 100, -7);
    push_tick(MODE_REV_ROTATE, 1'b0, -100, 9);
    push_tick(3'd5, 1'b1, 500, 1);
    push_tick(3'd6, 1'b0, -500, -1);
    push_tick(3'd7, 1'b1, 20, 3);
    push_tick(MODE_FOLLOW_YAW, 1'b1, 0, 32767);
    push_tick(MODE_FOLLOW_YAW, 1'b1, 0, -32768);
    // uncalibrated: sequence clears, then counts from wait on the same tick
    push_tick(MODE_FOLLOW_YAW, 1'b0, PITCH_MAX, 40);
    push_tick(MODE_FOLLOW_YAW, 1'b1, PITCH_MAX, 40);
    push_tick(MODE_FOLLOW_YAW, 1'b1, -PITCH_MAX, 10);
    push_tick(MODE_FOLLOW_YAW, 1'b1, -PITCH_MAX, 10);
    // stage two ends on timeout
    repeat (3) push_tick(MODE_FOLLOW_YAW, 1'b1, PITCH_MAX, 50);
    repeat (2) push_tick(MODE_FOLLOW_YAW, 1'b1, 400, 20);
    repeat (2) push_tick(MODE_FOLLOW_YAW, 1'b1, -100, -20);
    // stage two ends on confirm count
    repeat (2) push_tick(MODE_FOLLOW_YAW, 1'b1, -PITCH_MAX, 30);
    push_tick(MODE_ZERO_FORCE, 1'b1, 0, 0);
    push_tick(MODE_FOLLOW_YAW, 1'b0, -PITCH_MAX, -1);
    drain();

    for (int p = 0; p < 8; p++) begin
      plan = random_plan(p);
      write_plan(plan);
      stall_en = (p != 3);
      goal = queued + 100;
      while (queued < goal) begin
        if ($urandom_range(99) < 75) queue_climb(plan);
        else repeat ($urandom_range(5, 1)) push_noise();
      end
      drain();
    end

    $display("covered %0d ticks under %0d register settings, %0d words checked",
             ticks_in, settings, words_out);
    $display("climbs started %0d, stage two exits %0d, mismatches %0d",
             climbs_started, climbs_ended, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
